/* rtl/core/rlcq_pkg.sv */
// ----------------------------------------------------------------------------
// rlcq_pkg
// Types and codes for the receive line command queue.
// ----------------------------------------------------------------------------
package rlcq_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int SLOT_BYTES_DEF = 32;

	localparam logic [7:0] LINE_END = 8'h0D;
	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [3:0] WAIT_MAX = 4'd15;

	localparam logic [1:0] REQ_BYTE    = 2'd0;
	localparam logic [1:0] REQ_PEEK    = 2'd1;
	localparam logic [1:0] REQ_RELEASE = 2'd2;

	localparam logic [2:0] ST_STORED    = 3'd0;
	localparam logic [2:0] ST_LINE_DONE = 3'd1;
	localparam logic [2:0] ST_LINE_STOP = 3'd2;
	localparam logic [2:0] ST_DROPPED   = 3'd3;
	localparam logic [2:0] ST_NONE      = 3'd4;
	localparam logic [2:0] ST_WAITING   = 3'd5;
	localparam logic [2:0] ST_RELEASED  = 3'd6;
	localparam logic [2:0] ST_REJECTED  = 3'd7;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_CLEAR,
		FSM_PEEK,
		FSM_SWEEP
	} fsm_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
		logic [4:0] byte_index;
		logic [3:0] release_slot;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] head_slot;
		logic [7:0] data_byte;
		logic [3:0] pending_count;
		logic       receiver_stopped;
	} rsp_t;

endpackage

/* rtl/core/rx_line_command_queue.sv */
// ----------------------------------------------------------------------------
// rx_line_command_queue
// Ring of line slots that collects received bytes into command lines.
// ----------------------------------------------------------------------------
// A beat on req is taken when start is high and busy is low; its result shows
// on rsp for one cycle with done high and cannot be held off. A received byte
// returns its result on the next cycle and busy stays low. A peek passes
// through the synchronous read of the slot memory, then the PEEK state that
// returns the byte. A valid release returns its result on the next cycle but
// holds busy while the named slot is zeroed one byte per cycle through the
// single memory write port. After reset, busy is high while the whole slot
// memory is cleared.
// ----------------------------------------------------------------------------
module rx_line_command_queue #(
	parameter int SLOT_COUNT = rlcq_pkg::SLOT_COUNT_DEF,
	parameter int SLOT_BYTES = rlcq_pkg::SLOT_BYTES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rlcq_pkg::req_t req,
	output logic           done,
	output rlcq_pkg::rsp_t rsp
);

	localparam int DEPTH = SLOT_COUNT * SLOT_BYTES;
	localparam int SW = $clog2(SLOT_COUNT);
	localparam int PW = $clog2(SLOT_BYTES);
	localparam int AW = $clog2(DEPTH);

	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	rlcq_pkg::fsm_t state_q, state_d;
	logic [SW-1:0]  fill_q, fill_d;
	logic [SW-1:0]  read_q, read_d;
	logic [PW-1:0]  pos_q, pos_d;
	logic [3:0]     wait_q, wait_d;
	logic           stop_q, stop_d;
	logic [AW-1:0]  swp_addr_q, swp_addr_d;
	logic [AW-1:0]  swp_end_q, swp_end_d;
	logic           hit_q, hit_d;
	logic           done_q, done_d;
	rlcq_pkg::rsp_t rsp_q, rsp_d;

	logic           we;
	logic [AW-1:0]  waddr;
	logic [7:0]     wdata;
	logic [AW-1:0]  raddr;

	logic [SW-1:0]  fill_nxt;
	logic [SW-1:0]  read_nxt;
	logic [SW-1:0]  rel_slot;
	logic [AW-1:0]  fill_addr;
	logic [AW-1:0]  peek_addr;
	logic [AW-1:0]  rel_base;
	logic           accept;

	assign accept    = start && (state_q == rlcq_pkg::FSM_IDLE);
	assign fill_nxt  = (fill_q == SW'(SLOT_COUNT - 1)) ? '0 : fill_q + 1'b1;
	assign read_nxt  = (read_q == SW'(SLOT_COUNT - 1)) ? '0 : read_q + 1'b1;
	assign rel_slot  = SW'(req.release_slot);
	assign fill_addr = AW'(fill_q) * AW'(SLOT_BYTES) + AW'(pos_q);
	assign peek_addr = AW'(read_q) * AW'(SLOT_BYTES) + AW'(req.byte_index);
	assign rel_base  = AW'(rel_slot) * AW'(SLOT_BYTES);
	assign raddr     = peek_addr;

	always_comb begin
		state_d    = state_q;
		fill_d     = fill_q;
		read_d     = read_q;
		pos_d      = pos_q;
		wait_d     = wait_q;
		stop_d     = stop_q;
		swp_addr_d = swp_addr_q;
		swp_end_d  = swp_end_q;
		hit_d      = hit_q;
		done_d     = 1'b0;
		rsp_d      = rsp_q;
		we         = 1'b0;
		waddr      = fill_addr;
		wdata      = req.rx_byte;

		unique case (state_q)
			rlcq_pkg::FSM_CLEAR, rlcq_pkg::FSM_SWEEP: begin
				we    = 1'b1;
				waddr = swp_addr_q;
				wdata = rlcq_pkg::BYTE_ZERO;
				swp_addr_d = swp_addr_q + 1'b1;
				if (swp_addr_q == swp_end_q) begin
					state_d = rlcq_pkg::FSM_IDLE;
				end
			end
			rlcq_pkg::FSM_PEEK: begin
				done_d = 1'b1;
				rsp_d.data_byte = hit_q ? rd_q : rlcq_pkg::BYTE_ZERO;
				state_d = rlcq_pkg::FSM_IDLE;
			end
			default: begin
				if (accept) begin
					done_d = 1'b1;
					rsp_d.data_byte = rlcq_pkg::BYTE_ZERO;
					rsp_d.status = rlcq_pkg::ST_REJECTED;
					unique case (req.req_type)
						rlcq_pkg::REQ_BYTE: begin
							if (stop_q) begin
								rsp_d.status = rlcq_pkg::ST_DROPPED;
							end else if (req.rx_byte == rlcq_pkg::LINE_END) begin
								we    = 1'b1;
								wdata = rlcq_pkg::BYTE_ZERO;
								if (wait_q != rlcq_pkg::WAIT_MAX) begin
									wait_d = wait_q + 1'b1;
								end
								rsp_d.status = rlcq_pkg::ST_LINE_DONE;
								if (fill_nxt == read_q) begin
									stop_d = 1'b1;
									rsp_d.status = rlcq_pkg::ST_LINE_STOP;
								end
								fill_d = fill_nxt;
								pos_d  = '0;
							end else begin
								we    = 1'b1;
								pos_d = (pos_q == PW'(SLOT_BYTES - 1)) ? '0 : pos_q + 1'b1;
								rsp_d.status = rlcq_pkg::ST_STORED;
							end
						end
						rlcq_pkg::REQ_PEEK: begin
							done_d  = 1'b0;
							state_d = rlcq_pkg::FSM_PEEK;
							if ((read_q != fill_q) || stop_q) begin
								rsp_d.status = rlcq_pkg::ST_WAITING;
								hit_d = (32'(req.byte_index) < SLOT_BYTES);
							end else begin
								rsp_d.status = rlcq_pkg::ST_NONE;
								hit_d = 1'b0;
							end
						end
						rlcq_pkg::REQ_RELEASE: begin
							if (32'(req.release_slot) < SLOT_COUNT) begin
								if (wait_q != 4'd0) begin
									wait_d = wait_q - 1'b1;
								end
								read_d     = read_nxt;
								stop_d     = 1'b0;
								swp_addr_d = rel_base;
								swp_end_d  = rel_base + AW'(SLOT_BYTES - 1);
								state_d    = rlcq_pkg::FSM_SWEEP;
								rsp_d.status = rlcq_pkg::ST_RELEASED;
							end
						end
						default: begin
							rsp_d.status = rlcq_pkg::ST_REJECTED;
						end
					endcase
					rsp_d.head_slot        = 3'(read_d);
					rsp_d.pending_count    = wait_d;
					rsp_d.receiver_stopped = stop_d;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= rlcq_pkg::FSM_CLEAR;
			fill_q     <= '0;
			read_q     <= '0;
			pos_q      <= '0;
			wait_q     <= '0;
			stop_q     <= 1'b0;
			swp_addr_q <= '0;
			swp_end_q  <= AW'(DEPTH - 1);
			hit_q      <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			fill_q     <= fill_d;
			read_q     <= read_d;
			pos_q      <= pos_d;
			wait_q     <= wait_d;
			stop_q     <= stop_d;
			swp_addr_q <= swp_addr_d;
			swp_end_q  <= swp_end_d;
			hit_q      <= hit_d;
			done_q     <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign busy = (state_q != rlcq_pkg::FSM_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
